>>> sv/udrb_pkg.sv
// Shared constants, types and pointer helpers for the dual UART ring buffer.
package udrb_pkg;

    localparam int TX_DEPTH = 128;
    localparam int RX_DEPTH = 128;

    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam int RX_PW = $clog2(RX_DEPTH);

    typedef logic [TX_PW-1:0] t_tx_ptr;
    typedef logic [RX_PW-1:0] t_rx_ptr;
    typedef logic [2:0]       t_action;
    typedef logic [7:0]       t_byte;

    localparam t_action ACT_PUT   = 3'd0;
    localparam t_action ACT_GET   = 3'd1;
    localparam t_action ACT_RECV  = 3'd2;
    localparam t_action ACT_SLOT  = 3'd3;
    localparam t_action ACT_CLEAR = 3'd4;

    localparam t_tx_ptr TX_LAST = t_tx_ptr'(TX_DEPTH - 1);
    localparam t_rx_ptr RX_LAST = t_rx_ptr'(RX_DEPTH - 1);

    // Ring indices wrap at the last entry, so depths need not be powers of two.
    function automatic t_tx_ptr tx_adv(input t_tx_ptr p);
        return (p == TX_LAST) ? '0 : p + t_tx_ptr'(1);
    endfunction

    function automatic t_rx_ptr rx_adv(input t_rx_ptr p);
        return (p == RX_LAST) ? '0 : p + t_rx_ptr'(1);
    endfunction

endpackage

>>> sv/uart_dual_ring_buffer.sv
// Dual byte ring buffer between an application and a serial transmitter/receiver.
//
// Requests enter on start with i_action, i_data_byte and i_tx_busy. busy is held low,
// so a request is taken on every clock edge at which start is high.
// Actions: application put into the transmit ring, application get from the receive
// ring, received byte into the receive ring, transmitter slot taking the oldest
// transmit byte, and clear of all pointers and the drop counter.
// Each ring keeps one slot empty and so holds at most depth minus one bytes.
// The request is registered, decided against the ring pointers in the next cycle
// while the ring memory is read; the result then passes into the result register and shows
// for exactly one cycle, marked by o_done. One request per cycle is sustained; the
// memory port read for the oldest byte is the only registered lookup in the path.
// The receiver must take each result in its strobe cycle; nothing is held back.
// A synchronous active-low reset empties both rings, zeroes the drop counter and
// discards any request in flight. Memory contents are not cleared: only entries
// between read and write pointers are ever handed out.
module uart_dual_ring_buffer
    import udrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_tx_busy,
    output logic        o_done,
    output logic        o_accepted,
    output logic [7:0]  o_byte_out,
    output logic        o_byte_valid,
    output logic        o_tx_irq_enable,
    output logic        o_tx_pending,
    output logic [31:0] o_drop_count
);

    // Request register.
    logic    r_in_valid;
    t_action r_action;
    t_byte   r_data;
    logic    r_in_busy;

    // Ring state.
    t_tx_ptr     r_tx_wp, n_tx_wp, r_tx_rp, n_tx_rp;
    t_rx_ptr     r_rx_wp, n_rx_wp, r_rx_rp, n_rx_rp;
    logic [31:0] r_drop, n_drop;

    // Result register.
    logic r_done, r_acc, n_acc, r_bvalid, n_bvalid, r_sel_rx, n_sel_rx, r_res_busy;

    logic  tx_we, rx_we;
    t_byte tx_q, rx_q;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_action  <= i_action;
        r_data    <= i_data_byte;
        r_in_busy <= i_tx_busy;
    end

    always_comb begin
        n_tx_wp  = r_tx_wp;
        n_tx_rp  = r_tx_rp;
        n_rx_wp  = r_rx_wp;
        n_rx_rp  = r_rx_rp;
        n_drop   = r_drop;
        n_acc    = 1'b0;
        n_bvalid = 1'b0;
        n_sel_rx = 1'b0;
        tx_we    = 1'b0;
        rx_we    = 1'b0;
        if (r_in_valid) begin
            unique case (r_action)
                ACT_PUT: begin
                    if (tx_adv(r_tx_wp) != r_tx_rp) begin
                        tx_we   = 1'b1;
                        n_tx_wp = tx_adv(r_tx_wp);
                        n_acc   = 1'b1;
                    end
                end
                ACT_GET: begin
                    if (r_rx_rp != r_rx_wp) begin
                        n_rx_rp  = rx_adv(r_rx_rp);
                        n_acc    = 1'b1;
                        n_bvalid = 1'b1;
                        n_sel_rx = 1'b1;
                    end
                end
                ACT_RECV: begin
                    if (rx_adv(r_rx_wp) == r_rx_rp) begin
                        n_drop = r_drop + 32'd1;
                    end else begin
                        rx_we   = 1'b1;
                        n_rx_wp = rx_adv(r_rx_wp);
                        n_acc   = 1'b1;
                    end
                end
                ACT_SLOT: begin
                    if (r_tx_rp != r_tx_wp) begin
                        n_tx_rp  = tx_adv(r_tx_rp);
                        n_acc    = 1'b1;
                        n_bvalid = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    n_tx_wp = '0;
                    n_tx_rp = '0;
                    n_rx_wp = '0;
                    n_rx_rp = '0;
                    n_drop  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wp <= '0;
            r_tx_rp <= '0;
            r_rx_wp <= '0;
            r_rx_rp <= '0;
            r_drop  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_tx_wp <= n_tx_wp;
            r_tx_rp <= n_tx_rp;
            r_rx_wp <= n_rx_wp;
            r_rx_rp <= n_rx_rp;
            r_drop  <= n_drop;
            r_done  <= r_in_valid;
        end
        r_acc      <= n_acc;
        r_bvalid   <= n_bvalid;
        r_sel_rx   <= n_sel_rx;
        r_res_busy <= r_in_busy;
    end

    // Both memories are read at their read pointer every cycle, so the oldest byte
    // lands in the read register at the same edge as the result.
    udrb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wp),
        .i_wdata (r_data),
        .i_raddr (r_tx_rp),
        .o_rdata (tx_q)
    );

    udrb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wp),
        .i_wdata (r_data),
        .i_raddr (r_rx_rp),
        .o_rdata (rx_q)
    );

    // Pointers and counter already hold the state after the reported request.
    assign o_done          = r_done;
    assign o_accepted      = r_acc;
    assign o_byte_valid    = r_bvalid;
    assign o_byte_out      = r_bvalid ? (r_sel_rx ? rx_q : tx_q) : 8'h00;
    assign o_tx_irq_enable = r_tx_rp != r_tx_wp;
    assign o_tx_pending    = (r_tx_rp != r_tx_wp) || r_res_busy;
    assign o_drop_count    = r_drop;

endmodule

>>> sv/udrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/udrb_checker.sv
// Port-level checker for the dual UART ring buffer, bound to the top level.
module udrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_accepted,
    input logic        o_byte_valid,
    input logic        o_tx_irq_enable,
    input logic        o_tx_pending
);

    // Every request taken yields a result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start && !busy && i_rst_n, 2) && $past(i_rst_n)) |-> o_done)
        else $error("request without result");

    // No result appears without an earlier request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without request");

    a_byte_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_byte_valid) |-> o_accepted)
        else $error("byte handed out on a refused request");

    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_tx_irq_enable) |-> o_tx_pending)
        else $error("transmit data waiting but not pending");

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_accepted      (o_accepted),
    .o_byte_valid    (o_byte_valid),
    .o_tx_irq_enable (o_tx_irq_enable),
    .o_tx_pending    (o_tx_pending)
);

>>> tb/uart_dual_ring_buffer_tb.sv
// Self-checking testbench for the dual UART ring buffer: random request stream, local ring model.
module uart_dual_ring_buffer_tb;
    import udrb_pkg::*;

    // Action codes 5 to 7 carry no operation; the block must ignore them.
    localparam t_action ACT_SPARE_FIRST = 3'd5;
    localparam t_action ACT_SPARE_LAST  = 3'd7;

    localparam int TARGET_ITEMS = 1800;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        t_action act;
        t_byte   data;
        logic    tx_busy;
    } ring_request_t;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic        tx_irq_enable;
        logic        tx_pending;
        logic [31:0] drop_count;
    } ring_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [7:0]  i_data_byte;
    logic        i_tx_busy;
    logic        o_done;
    logic        o_accepted;
    logic [7:0]  o_byte_out;
    logic        o_byte_valid;
    logic        o_tx_irq_enable;
    logic        o_tx_pending;
    logic [31:0] o_drop_count;

    uart_dual_ring_buffer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_tx_busy      (i_tx_busy),
        .o_done         (o_done),
        .o_accepted     (o_accepted),
        .o_byte_out     (o_byte_out),
        .o_byte_valid   (o_byte_valid),
        .o_tx_irq_enable(o_tx_irq_enable),
        .o_tx_pending   (o_tx_pending),
        .o_drop_count   (o_drop_count)
    );

    ring_request_t requests_to_send[$];
    ring_result_t  results_owed[$];

    // Local copy of both rings and the drop counter.
    t_byte       tx_ring[TX_DEPTH];
    t_byte       rx_ring[RX_DEPTH];
    t_tx_ptr     tx_wr, tx_rd;
    t_rx_ptr     rx_wr, rx_rd;
    logic [31:0] drops_seen;

    bit feeding;
    bit took_req;
    int idle_left;
    int mismatches;
    int counted_items;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic ring_result_t step_rings(t_action act, t_byte data, logic busy_in);
        ring_result_t r;
        t_tx_ptr      tx_next;
        t_rx_ptr      rx_next;
        r = '0;
        tx_next = (int'(tx_wr) == TX_DEPTH - 1) ? '0 : tx_wr + 1'b1;
        rx_next = (int'(rx_wr) == RX_DEPTH - 1) ? '0 : rx_wr + 1'b1;
        case (act)
            ACT_PUT: begin
                if (tx_next != tx_rd) begin
                    tx_ring[tx_wr] = data;
                    tx_wr = tx_next;
                    r.accepted = 1'b1;
                end
            end
            ACT_GET: begin
                if (rx_rd != rx_wr) begin
                    r.byte_out = rx_ring[rx_rd];
                    rx_rd = (int'(rx_rd) == RX_DEPTH - 1) ? '0 : rx_rd + 1'b1;
                    r.accepted = 1'b1;
                    r.byte_valid = 1'b1;
                end
            end
            ACT_RECV: begin
                if (rx_next == rx_rd) begin
                    drops_seen = drops_seen + 1;
                end else begin
                    rx_ring[rx_wr] = data;
                    rx_wr = rx_next;
                    r.accepted = 1'b1;
                end
            end
            ACT_SLOT: begin
                if (tx_rd != tx_wr) begin
                    r.byte_out = tx_ring[tx_rd];
                    tx_rd = (int'(tx_rd) == TX_DEPTH - 1) ? '0 : tx_rd + 1'b1;
                    r.accepted = 1'b1;
                    r.byte_valid = 1'b1;
                end
            end
            ACT_CLEAR: begin
                tx_wr = '0;
                tx_rd = '0;
                rx_wr = '0;
                rx_rd = '0;
                drops_seen = '0;
            end
            default: begin
            end
        endcase
        r.tx_irq_enable = (tx_rd != tx_wr);
        r.tx_pending    = r.tx_irq_enable | busy_in;
        r.drop_count    = drops_seen;
        return r;
    endfunction

    task automatic queue_request(t_action act, t_byte data, bit busy_bit);
        ring_request_t q;
        q.act = act;
        q.data = data;
        q.tx_busy = busy_bit;
        requests_to_send.push_back(q);
        if (act < ACT_SPARE_FIRST)
            counted_items++;
    endtask

    task automatic queue_burst(t_action act, int n);
        for (int k = 0; k < n; k++)
            queue_request(act, t_byte'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic log_mismatch(string what, ring_result_t want, ring_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: exp %b %h %b %b %b %0d | got %b %h %b %b %b %0d",
                     $time, what, want.accepted, want.byte_out, want.byte_valid,
                     want.tx_irq_enable, want.tx_pending, want.drop_count,
                     got.accepted, got.byte_out, got.byte_valid,
                     got.tx_irq_enable, got.tx_pending, got.drop_count);
    endtask

    // Driver: presents the front request; it is removed once the edge has taken it.
    always @(negedge i_clk) begin : drive_requests
        bit send;
        if (took_req)
            void'(requests_to_send.pop_front());
        send = 1'b0;
        if (!feeding) begin
            send = 1'b0;
        end else if (idle_left > 0) begin
            idle_left--;
        end else if (requests_to_send.size() > CALM_TAIL && !(start && !took_req)
                     && $urandom_range(0, 9) == 0) begin
            idle_left = $urandom_range(1, 6) - 1;
        end else begin
            send = (requests_to_send.size() != 0);
        end
        start <= send;
        if (send) begin
            i_action    <= requests_to_send[0].act;
            i_data_byte <= requests_to_send[0].data;
            i_tx_busy   <= requests_to_send[0].tx_busy;
        end
    end

    // Monitor: checks each strobed result, then predicts for the request taken at this edge.
    always @(posedge i_clk) begin : watch_results
        ring_result_t got;
        ring_result_t want;
        if (!i_rst_n) begin
            took_req <= 1'b0;
        end else begin
            if (o_done) begin
                got = {o_accepted, o_byte_out, o_byte_valid, o_tx_irq_enable,
                       o_tx_pending, o_drop_count};
                if (results_owed.size() == 0) begin
                    log_mismatch("result with no request outstanding", '0, got);
                end else begin
                    want = results_owed.pop_front();
                    if (got.accepted !== want.accepted || got.byte_out !== want.byte_out
                        || got.byte_valid !== want.byte_valid
                        || got.tx_irq_enable !== want.tx_irq_enable
                        || got.tx_pending !== want.tx_pending
                        || got.drop_count !== want.drop_count)
                        log_mismatch("result mismatch", want, got);
                end
            end
            if (start && !busy)
                results_owed.push_back(step_rings(t_action'(i_action), i_data_byte, i_tx_busy));
            took_req <= start && !busy;
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : run_test
        int pick;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_action    = ACT_PUT;
        i_data_byte = 8'h00;
        i_tx_busy   = 1'b0;
        feeding     = 1'b0;
        idle_left   = 0;
        mismatches  = 0;
        counted_items = 0;
        tx_wr = '0;
        tx_rd = '0;
        rx_wr = '0;
        rx_rd = '0;
        drops_seen = '0;

        // Empty rings, byte extremes, both busy levels, spare codes and clear.
        queue_request(ACT_GET, 8'h00, 1'b0);
        queue_request(ACT_SLOT, 8'hff, 1'b0);
        queue_request(ACT_PUT, 8'h00, 1'b0);
        queue_request(ACT_PUT, 8'hff, 1'b1);
        queue_request(ACT_SLOT, 8'h00, 1'b0);
        queue_request(ACT_SLOT, 8'h00, 1'b1);
        queue_request(ACT_SLOT, 8'h00, 1'b0);
        queue_request(ACT_SLOT, 8'h00, 1'b1);
        queue_request(ACT_RECV, 8'hff, 1'b0);
        queue_request(ACT_RECV, 8'h00, 1'b1);
        queue_request(ACT_GET, 8'h55, 1'b0);
        queue_request(ACT_GET, 8'haa, 1'b1);
        queue_request(ACT_GET, 8'h00, 1'b0);
        for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++)
            queue_request(t_action'(c), 8'hff, 1'b1);
        queue_request(ACT_PUT, 8'ha5, 1'b0);
        queue_request(ACT_RECV, 8'h5a, 1'b0);
        queue_request(ACT_CLEAR, 8'hff, 1'b1);
        queue_request(ACT_SLOT, 8'h00, 1'b0);
        queue_request(ACT_GET, 8'h00, 1'b1);

        // Random part is built from bursts so that both rings fill, overrun and wrap.
        while (counted_items < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                queue_burst(ACT_PUT, $urandom_range(100, 140));
            else if (pick < 36)
                queue_burst(ACT_SLOT, $urandom_range(20, 140));
            else if (pick < 54)
                queue_burst(ACT_RECV, $urandom_range(100, 140));
            else if (pick < 72)
                queue_burst(ACT_GET, $urandom_range(20, 140));
            else if (pick < 94) begin
                repeat ($urandom_range(10, 40)) begin
                    case ($urandom_range(0, 3))
                        0:       queue_burst(ACT_PUT, 1);
                        1:       queue_burst(ACT_GET, 1);
                        2:       queue_burst(ACT_RECV, 1);
                        default: queue_burst(ACT_SLOT, 1);
                    endcase
                end
            end else if (pick < 97) begin
                queue_burst(ACT_CLEAR, 1);
            end else begin
                repeat ($urandom_range(1, 3))
                    queue_request(t_action'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                                  t_byte'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        feeding <= 1'b1;

        while (requests_to_send.size() != 0)
            @(posedge i_clk);
        while (results_owed.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && results_owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
